@@ hdl/rwedf_pkg.sv @@
package rwedf_pkg;

  localparam int unsigned COORD_W        = 12;
  localparam int unsigned SPAN_W         = 12;
  localparam int unsigned MAX_SPAN_RESET = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SPAN_W-1:0]  span_t;

endpackage

@@ hdl/rwedf_evt_if.sv @@
interface rwedf_evt_if import rwedf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t row;
  coord_t column;

  modport source (output valid, output row, output column, input ready);
  modport sink   (input valid, input row, input column, output ready);
endinterface

@@ hdl/rwedf_res_if.sv @@
interface rwedf_res_if import rwedf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_row;
  coord_t out_column;
  logic   last;

  modport source (output valid, output out_row, output out_column, output last, input ready);
  modport sink   (input valid, input out_row, input out_column, input last, output ready);
endinterface

@@ hdl/rwedf_cfg_if.sv @@
interface rwedf_cfg_if import rwedf_pkg::*; ();
  logic  valid;
  logic  ready;
  span_t max_span;

  modport source (output valid, output max_span, input ready);
  modport sink   (input valid, input max_span, output ready);
endinterface

@@ hdl/rwedf_hist.sv @@
module rwedf_hist import rwedf_pkg::*; #(
  parameter int unsigned WINDOW = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  coord_t                        row_i,
  input  coord_t                        column_i,
  input  span_t                         max_span_i,
  output logic                          burst_valid_o,
  output coord_t                        burst_row_o,
  output logic [WINDOW-1:0][COORD_W-1:0] burst_cols_o,
  output logic [WINDOW-1:0]             burst_mask_o
);

  localparam int unsigned HIST   = WINDOW - 1;
  localparam int unsigned FILL_W = $clog2(WINDOW);

  coord_t                   cur_row_q, cur_row_d;
  logic [HIST-1:0][COORD_W-1:0] cols_q, cols_d;
  logic [HIST-1:0]          emit_q, emit_d;
  logic [FILL_W-1:0]        fill_q, fill_d;

  logic                     new_row;
  logic [FILL_W-1:0]        fill_eff;
  logic [HIST-1:0]          emit_eff;
  logic                     full;
  logic signed [COORD_W:0]  span;
  logic                     pass;

  always_comb begin
    new_row  = (row_i != cur_row_q);
    fill_eff = new_row ? '0 : fill_q;
    emit_eff = new_row ? '0 : emit_q;
    full     = (fill_eff >= FILL_W'(HIST));
    // signed span, a descending column gives a negative value that always passes
    span     = $signed({1'b0, column_i}) - $signed({1'b0, cols_q[0]});
    pass     = span < $signed({1'b0, max_span_i});

    cur_row_d = cur_row_q;
    cols_d    = cols_q;
    emit_d    = emit_q;
    fill_d    = fill_q;

    for (int i = 0; i < HIST; i++) begin
      burst_cols_o[i] = cols_q[i];
      burst_mask_o[i] = pass & ~emit_eff[i];
    end
    burst_cols_o[HIST] = column_i;
    burst_mask_o[HIST] = pass;
    burst_row_o        = row_i;
    burst_valid_o      = accept_i & full & pass;

    if (accept_i) begin
      cur_row_d = row_i;
      if (!full) begin
        emit_d = emit_eff;
        for (int i = 0; i < HIST; i++) begin
          if (FILL_W'(i) == fill_eff) begin
            cols_d[i] = column_i;
            emit_d[i] = 1'b0;
          end
        end
        fill_d = fill_eff + 1'b1;
      end else begin
        // a passing window leaves every held event marked as sent
        for (int i = 0; i + 1 < HIST; i++) begin
          cols_d[i] = cols_q[i+1];
          emit_d[i] = emit_eff[i+1] | pass;
        end
        cols_d[HIST-1] = column_i;
        emit_d[HIST-1] = pass;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cols_q    <= '0;
      emit_q    <= '0;
      fill_q    <= '0;
    end else begin
      cur_row_q <= cur_row_d;
      cols_q    <= cols_d;
      emit_q    <= emit_d;
      fill_q    <= fill_d;
    end
  end

endmodule

@@ hdl/rwedf_emit.sv @@
module rwedf_emit import rwedf_pkg::*; #(
  parameter int unsigned WINDOW = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  coord_t                         row_i,
  input  logic [WINDOW-1:0][COORD_W-1:0] cols_i,
  input  logic [WINDOW-1:0]              mask_i,
  output logic                           free_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output coord_t                         out_row_o,
  output coord_t                         out_column_o,
  output logic                           last_o
);

  localparam int unsigned SEL_W = $clog2(WINDOW);

  coord_t                         row_q;
  logic [WINDOW-1:0][COORD_W-1:0] cols_q;
  logic [WINDOW-1:0]              mask_q, mask_d;
  logic [WINDOW-1:0]              low_bit, rest;
  logic [SEL_W-1:0]               sel;

  always_comb begin
    sel = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = SEL_W'(i);
    end
    low_bit = mask_q & (~mask_q + 1'b1);
    rest    = mask_q & ~low_bit;

    valid_o      = |mask_q;
    last_o       = (rest == '0);
    out_row_o    = row_q;
    out_column_o = cols_q[sel];
    // burst register can take a new burst once its final transaction goes out
    free_o       = !valid_o || (ready_i && last_o);

    mask_d = mask_q;
    if (valid_o && ready_i) mask_d = rest;
    if (load_i) mask_d = mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q  <= row_i;
      cols_q <= cols_i;
    end
  end

endmodule

@@ hdl/row_window_event_density_filter.sv @@
// row window event density filter
// evt_i carries sensor events (row, column), sorted by row and then by column.
// res_o carries the kept events, oldest first; last marks the final kept event
// caused by one input transaction. cfg_i writes max_span, taken in any cycle.
// each event beyond a row's first WINDOW-1 closes a window with its previous WINDOW-1 events;
// when the column span is below max_span the window's not yet emitted events
// form a burst of 1 to WINDOW results in a burst register.
// the first result of an event is valid in the cycle after its accept.
// throughput: one event per cycle while no burst is waiting; a burst of several results
// holds evt_i.ready low until its final result goes out, set by the single burst register. a row
// whose windows keep passing gives bursts of one, so it runs at one event per cycle.
// when the receiver stalls, the burst stays put and evt_i.ready drops.
// reset clears the row history and any pending burst and sets max_span to 6.
module row_window_event_density_filter import rwedf_pkg::*; #(
  parameter int unsigned WINDOW = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwedf_evt_if.sink   evt_i,
  rwedf_res_if.source res_o,
  rwedf_cfg_if.sink   cfg_i
);

  span_t                          max_span_q;
  logic                           free;
  logic                           evt_accept;
  logic                           burst_valid;
  coord_t                         burst_row;
  logic [WINDOW-1:0][COORD_W-1:0] burst_cols;
  logic [WINDOW-1:0]              burst_mask;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = free;
  assign evt_accept  = evt_i.valid & free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_span_q <= SPAN_W'(MAX_SPAN_RESET);
    end else if (cfg_i.valid) begin
      max_span_q <= cfg_i.max_span;
    end
  end

  rwedf_hist #(.WINDOW(WINDOW)) u_hist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (evt_accept),
    .row_i         (evt_i.row),
    .column_i      (evt_i.column),
    .max_span_i    (max_span_q),
    .burst_valid_o (burst_valid),
    .burst_row_o   (burst_row),
    .burst_cols_o  (burst_cols),
    .burst_mask_o  (burst_mask)
  );

  rwedf_emit #(.WINDOW(WINDOW)) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (burst_valid),
    .row_i        (burst_row),
    .cols_i       (burst_cols),
    .mask_i       (burst_mask),
    .free_o       (free),
    .valid_o      (res_o.valid),
    .ready_i      (res_o.ready),
    .out_row_o    (res_o.out_row),
    .out_column_o (res_o.out_column),
    .last_o       (res_o.last)
  );

endmodule

@@ hdl/rwedf_checker.sv @@
module rwedf_checker import rwedf_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   evt_ready_i,
  input logic   res_valid_i,
  input logic   res_ready_i,
  input coord_t res_row_i,
  input coord_t res_column_i,
  input logic   res_last_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(res_row_i) && $stable(res_column_i) && $stable(res_last_i))
    else $error("result payload changed while stalled");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i)
    else $error("burst ended without last");

  a_burst_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_row_i == $past(res_row_i))
    else $error("row changed inside a burst");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |-> !evt_ready_i)
    else $error("input taken while burst still pending");

endmodule

bind row_window_event_density_filter rwedf_checker u_rwedf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .evt_ready_i  (evt_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_row_i    (res_o.out_row),
  .res_column_i (res_o.out_column),
  .res_last_i   (res_o.last)
);

@@ tb/tb_row_window_event_density_filter.sv @@
`timescale 1ns / 1ps

module tb_row_window_event_density_filter;
  import rwedf_pkg::*;

  localparam int unsigned WINDOW      = 3;
  localparam int unsigned HIST        = WINDOW - 1;
  localparam int unsigned RAND_EVENTS = 480;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned HOLD_AT     = 250;
  localparam int unsigned HOLD_LEN    = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PRINT_CAP   = 60;
  localparam int          FREE        = -1;

  typedef enum logic {DIR_EVENT, DIR_SPAN} dir_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_mode_e;

  typedef struct {
    dir_kind_e   kind;
    coord_t      row;
    coord_t      column;
    span_t       span;
    bit          typed;
    int unsigned n;
    coord_t      cols [WINDOW];
  } dir_step_t;

  typedef struct {
    coord_t row;
    coord_t column;
    logic   last;
  } kept_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rwedf_evt_if evt ();
  rwedf_res_if res ();
  rwedf_cfg_if cfg ();

  row_window_event_density_filter #(
    .WINDOW (WINDOW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // row history as the block should hold it
  coord_t      cur_row              = '0;
  coord_t      held_col  [HIST]     = '{default: '0};
  bit          held_sent [HIST]     = '{default: 1'b0};
  int unsigned held_n               = 0;
  span_t       span_lim             = span_t'(MAX_SPAN_RESET);

  kept_t       kept_q  [$];
  dir_step_t   sent_q  [$];
  dir_step_t   dir_tab [$];

  int unsigned errors       = 0;
  int unsigned events_in    = 0;
  int unsigned dir_events   = 0;
  int unsigned kept_seen    = 0;
  int unsigned stall_cycles = 0;
  int unsigned evt_burst    = 0;
  bit          evt_up       = 1'b0;

  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_left      = 0;
  int unsigned rx_tick      = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_CAP) $display("mismatch: %s", what);
    errors++;
  endtask

  // advances the row history by one event and returns the kept events it releases
  function automatic int unsigned filter_event(input coord_t r, input coord_t c,
                                               output kept_t out [WINDOW]);
    int          span_d;
    int unsigned n;
    int          i;
    bit          keep;
    n = 0;
    for (i = 0; i < WINDOW; i++) out[i] = '{r, '0, 1'b0};
    if (r != cur_row) begin
      cur_row   = r;
      held_n    = 0;
      held_sent = '{default: 1'b0};
    end
    if (held_n < HIST) begin
      held_col[held_n]  = c;
      held_sent[held_n] = 1'b0;
      held_n++;
      return 0;
    end
    // signed span, so a descending column always passes
    span_d = int'(c) - int'(held_col[0]);
    keep   = span_d < int'(span_lim);
    if (keep) begin
      for (i = 0; i < HIST; i++) begin
        if (!held_sent[i]) begin
          out[n] = '{r, held_col[i], 1'b0};
          n++;
          held_sent[i] = 1'b1;
        end
      end
      out[n] = '{r, c, 1'b1};
      n++;
    end
    for (i = 0; i + 1 < HIST; i++) begin
      held_col[i]  = held_col[i + 1];
      held_sent[i] = held_sent[i + 1];
    end
    held_col[HIST - 1]  = c;
    held_sent[HIST - 1] = keep;
    return n;
  endfunction

  function automatic void add_event(input int r, input int c, input int n,
                                    input int c0, input int c1, input int c2);
    dir_step_t s;
    s.kind    = DIR_EVENT;
    s.row     = coord_t'(r);
    s.column  = coord_t'(c);
    s.span    = '0;
    s.typed   = (n >= 0);
    s.n       = (n >= 0) ? n : 0;
    s.cols[0] = coord_t'(c0);
    s.cols[1] = coord_t'(c1);
    s.cols[2] = coord_t'(c2);
    dir_tab.push_back(s);
  endfunction

  function automatic void add_span(input int v);
    dir_step_t s;
    s.kind   = DIR_SPAN;
    s.row    = '0;
    s.column = '0;
    s.span   = span_t'(v);
    s.typed  = 1'b0;
    s.n      = 0;
    s.cols   = '{default: '0};
    dir_tab.push_back(s);
  endfunction

  task automatic pause_events();
    if (evt_up) begin
      evt.valid <= 1'b0;
      evt_up = 1'b0;
    end
  endtask

  // offers one event in bursts; valid stays high into the next call of a burst
  task automatic send_event(input dir_step_t step);
    int unsigned gap;
    if (evt_burst == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pause_events();
        repeat (gap) @(posedge clk_i);
      end
      evt_burst = $urandom_range(1, 24);
    end
    evt_burst--;
    sent_q.push_back(step);
    evt.valid  <= 1'b1;
    evt.row    <= step.row;
    evt.column <= step.column;
    evt_up = 1'b1;
    do @(negedge clk_i); while (!evt.ready);
    @(posedge clk_i);
  endtask

  task automatic write_span(input span_t v);
    pause_events();
    evt_burst = 0;
    while (kept_q.size() != 0 || sent_q.size() != 0) @(posedge clk_i);
    // an event with no result may still be in flight
    repeat (SETTLE) @(posedge clk_i);
    cfg.valid    <= 1'b1;
    cfg.max_span <= v;
    do @(negedge clk_i); while (!cfg.ready);
    @(posedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // mostly clustered rows with random content, the rest scattered noise
  task automatic run_phase(input span_t lim, input int unsigned count);
    dir_step_t   step;
    int unsigned done;
    int unsigned len;
    int unsigned gap_hi;
    int unsigned k;
    int unsigned nxt;
    coord_t      c;
    write_span(lim);
    gap_hi      = (lim < 2) ? 1 : lim;
    done        = 0;
    step.kind   = DIR_EVENT;
    step.row    = '0;
    step.column = '0;
    step.span   = '0;
    step.typed  = 1'b0;
    step.n      = 0;
    step.cols   = '{default: '0};
    while (done < count) begin
      if ($urandom_range(0, 99) < 85) begin
        step.row = coord_t'($urandom_range(0, 4095));
        c        = coord_t'($urandom_range(0, 4095));
        len      = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          step.column = c;
          send_event(step);
          done++;
          nxt = c + $urandom_range(0, gap_hi);
          c   = (nxt > 4095) ? 12'hFFF : coord_t'(nxt);
        end
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 1) == 1) step.row = coord_t'($urandom_range(0, 4095));
          step.column = coord_t'($urandom_range(0, 4095));
          send_event(step);
          done++;
        end
      end
    end
  endtask

  // handshakes are sampled mid-cycle, where nothing changes
  always @(negedge clk_i) begin : port_watch
    kept_t       pred [WINDOW];
    kept_t       want;
    dir_step_t   step;
    int unsigned n;
    int          i;
    if (rst_ni) begin
      stall_cycles++;
      if (cfg.valid && cfg.ready) begin
        span_lim     = cfg.max_span;
        stall_cycles = 0;
      end
      if (evt.valid && evt.ready) begin
        step = sent_q.pop_front();
        n    = filter_event(evt.row, evt.column, pred);
        if (step.typed) begin
          n = step.n;
          for (i = 0; i < int'(n); i++) pred[i] = '{evt.row, step.cols[i], i == int'(n) - 1};
        end
        for (i = 0; i < int'(n); i++) kept_q.push_back(pred[i]);
        events_in++;
        stall_cycles = 0;
      end
      if (res.valid && res.ready) begin
        stall_cycles = 0;
        kept_seen++;
        if (kept_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result row %0d column %0d last %0b",
                                  res.out_row, res.out_column, res.last));
        end else begin
          want = kept_q.pop_front();
          if (res.out_row !== want.row)
            flag_mismatch($sformatf("out_row %0d, expected %0d (column %0d)",
                                    res.out_row, want.row, want.column));
          if (res.out_column !== want.column)
            flag_mismatch($sformatf("out_column %0d, expected %0d (row %0d)",
                                    res.out_column, want.column, want.row));
          if (res.last !== want.last)
            flag_mismatch($sformatf("last %0b, expected %0b (row %0d column %0d)",
                                    res.last, want.last, want.row, want.column));
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    rx_tick++;
    if (!hold_done && events_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:        res.ready <= 1'b1;
        RX_COIN:        res.ready <= 1'($urandom_range(0, 1));
        RX_EVERY_THIRD: res.ready <= (rx_tick % 3) != 0;
        default:        res.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    span_t spans [PHASES];
    evt.valid    <= 1'b0;
    evt.row      <= '0;
    evt.column   <= '0;
    cfg.valid    <= 1'b0;
    cfg.max_span <= '0;

    // reset span of 6: pass, re-pass of an emitted pair, fail, pass again
    add_event(0, 0, 0, 0, 0, 0);
    add_event(0, 2, 0, 0, 0, 0);
    add_event(0, 5, 3, 0, 2, 5);
    add_event(0, 7, 1, 7, 0, 0);
    add_event(0, 20, 0, 0, 0, 0);
    add_event(0, 21, 0, 0, 0, 0);
    add_event(0, 22, 3, 20, 21, 22);
    // short row, then a descending column
    add_event(1, 100, 0, 0, 0, 0);
    add_event(2, 10, 0, 0, 0, 0);
    add_event(2, 11, 0, 0, 0, 0);
    add_event(2, 3, 3, 10, 11, 3);
    add_event(2, 4, FREE, 0, 0, 0);
    add_span(4095);
    add_event(4095, 0, 0, 0, 0, 0);
    add_event(4095, 1, 0, 0, 0, 0);
    add_event(4095, 4094, 3, 0, 1, 4094);
    add_event(3, 0, 0, 0, 0, 0);
    add_event(3, 0, 0, 0, 0, 0);
    add_event(3, 4095, 0, 0, 0, 0);
    // zero span: only a negative span passes
    add_span(0);
    add_event(5, 9, 0, 0, 0, 0);
    add_event(5, 9, 0, 0, 0, 0);
    add_event(5, 9, 0, 0, 0, 0);
    add_event(5, 8, 3, 9, 9, 8);
    add_span(1);
    add_event(2048, 4095, 0, 0, 0, 0);
    add_event(2048, 4095, 0, 0, 0, 0);
    add_event(2048, 4095, 3, 4095, 4095, 4095);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == DIR_SPAN) begin
        write_span(dir_tab[i].span);
      end else begin
        send_event(dir_tab[i]);
        dir_events++;
      end
    end

    spans = '{span_t'(3), span_t'(1), span_t'(4095),
              span_t'($urandom_range(7, 200)), span_t'(MAX_SPAN_RESET)};
    foreach (spans[p]) run_phase(spans[p], RAND_EVENTS / PHASES);

    pause_events();
    while (kept_q.size() != 0 || sent_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE * 4) @(posedge clk_i);

    $display("ran %0d events (%0d directed), %0d kept events checked, %0d max_span settings",
             events_in, dir_events, kept_seen, PHASES + 3);
    $display("spans 0, 1 and 4095, short rows, descending columns, one %0d-cycle output hold",
             HOLD_LEN);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
